FILE: hdl/tlfp_pkg.sv
// Shared types and constants of the tagged length frame parser.
// No dependencies; imported by every module of the block.
package tlfp_pkg;

   // Length bytes after the image tag, least significant first
   localparam int LENGTH_BYTES = 4;
   // Length bytes that contribute to the 32-bit payload count
   localparam int COUNT_BYTES  = 4;
   localparam int SEEN_W       = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;

   // Tag characters
   localparam logic [7:0] CHAR_E = 8'h45;
   localparam logic [7:0] CHAR_R = 8'h52;
   localparam logic [7:0] CHAR_I = 8'h49;
   localparam logic [7:0] CHAR_M = 8'h4D;
   localparam logic [7:0] CHAR_G = 8'h47;

   // Frame kinds
   localparam logic KIND_ERR = 1'b0;
   localparam logic KIND_IMG = 1'b1;

   // Parser phase, one-hot
   typedef enum logic [6:0] {
      PH_HUNT = 7'b0000001,
      PH_E    = 7'b0000010,
      PH_ER   = 7'b0000100,
      PH_I    = 7'b0001000,
      PH_IM   = 7'b0010000,
      PH_LEN  = 7'b0100000,
      PH_DATA = 7'b1000000
   } phase_type;

   // One result transaction
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       frame_kind;
      logic       last_byte;
   } result_type;

endpackage

FILE: hdl/tlfp_parser.sv
// Frame parser state: tag hunt, length gathering and payload count.
// Depends on tlfp_pkg for the phase type, tag characters and result struct.
module tlfp_parser
   import tlfp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_accept,
   input  logic [7:0]       rx_byte,
   output logic             result_valid,
   output result_type       result
);

   phase_type         phase_ff, phase_in;
   logic              kind_ff, kind_in;
   logic [SEEN_W-1:0] seen_ff, seen_in;
   logic [31:0]       remaining_ff, remaining_in;
   logic [31:0]       len_acc;
   logic              last_len_byte;
   logic              last_payload;

   // Merge the current length byte into its lane of the count
   always_comb begin
      len_acc = remaining_ff;
      for (int k = 0; k < COUNT_BYTES; k++) begin
         if (k < LENGTH_BYTES && 32'(seen_ff) == k) begin
            len_acc[8*k +: 8] = len_acc[8*k +: 8] | rx_byte;
         end
      end
   end

   assign last_len_byte = (32'(seen_ff) == LENGTH_BYTES - 1);
   assign last_payload  = (remaining_ff <= 32'd1);

   // Next state for one accepted byte
   always_comb begin
      phase_in     = phase_ff;
      kind_in      = kind_ff;
      seen_in      = seen_ff;
      remaining_in = remaining_ff;
      result_valid = 1'b0;
      result.payload_byte = rx_byte;
      result.frame_kind   = kind_ff;
      result.last_byte    = last_payload;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == CHAR_E) begin
               phase_in = PH_E;
            end else if (rx_byte == CHAR_I) begin
               phase_in = PH_I;
            end
         end
         PH_E: begin
            phase_in = (rx_byte == CHAR_R) ? PH_ER : PH_HUNT;
         end
         PH_ER: begin
            if (rx_byte == CHAR_R) begin
               kind_in      = KIND_ERR;
               seen_in      = '0;
               remaining_in = '0;
               phase_in     = PH_LEN;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_I: begin
            phase_in = (rx_byte == CHAR_M) ? PH_IM : PH_HUNT;
         end
         PH_IM: begin
            if (rx_byte == CHAR_G) begin
               kind_in      = KIND_IMG;
               seen_in      = '0;
               remaining_in = '0;
               phase_in     = PH_LEN;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_LEN: begin
            if (kind_ff == KIND_ERR) begin
               // Single unsigned length byte; zero ends the frame at once
               remaining_in = {24'd0, rx_byte};
               seen_in      = '0;
               phase_in     = (rx_byte == 8'd0) ? PH_HUNT : PH_DATA;
            end else if (last_len_byte) begin
               seen_in      = '0;
               remaining_in = len_acc;
               phase_in     = (len_acc == 32'd0) ? PH_HUNT : PH_DATA;
            end else begin
               remaining_in = len_acc;
               seen_in      = seen_ff + 1'b1;
            end
         end
         PH_DATA: begin
            result_valid = 1'b1;
            if (last_payload) begin
               phase_in     = PH_HUNT;
               seen_in      = '0;
               remaining_in = '0;
            end else begin
               remaining_in = remaining_ff - 32'd1;
            end
         end
         default: begin
            phase_in     = PH_HUNT;
            seen_in      = '0;
            remaining_in = '0;
         end
      endcase
   end

   // Advance on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         kind_ff      <= KIND_ERR;
         seen_ff      <= '0;
         remaining_ff <= '0;
      end else if (byte_accept) begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         seen_ff      <= seen_in;
         remaining_ff <= remaining_in;
      end
   end

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (remaining_ff != 32'd0))
      else $error("payload phase entered with zero count");

   a_result_only_data: assert property (@(posedge clock) disable iff (reset)
      result_valid |-> (phase_ff == PH_DATA))
      else $error("result raised outside payload phase");

   a_last_returns_hunt: assert property (@(posedge clock) disable iff (reset)
      (byte_accept && result_valid && result.last_byte) |=> (phase_ff == PH_HUNT))
      else $error("parser did not return to hunt after last payload byte");

endmodule

FILE: hdl/tlfp_out_buf.sv
// Two-entry output buffer (result register plus skid register).
// Depends on tlfp_pkg for the result struct.
module tlfp_out_buf
   import tlfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_data_ff, main_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       pop;

   assign pop       = main_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   // Refill the result register from the skid register first
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            main_valid_in = push;
            main_data_in  = push_data;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   // Hold or advance the two entries
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held with empty result register");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("transaction pushed into a full buffer");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_ready) |=> (main_valid_ff && main_data_ff == $past(skid_data_ff)))
      else $error("skid entry not moved into result register");

endmodule

FILE: hdl/tagged_length_frame_parser.sv
// Top level of the tagged length frame parser: byte stream in, payload stream out.
// Depends on tlfp_pkg, tlfp_parser and tlfp_out_buf.
//
// Usage:
//   The req_ channel carries received link bytes, one per transaction. The
//   parser hunts for the tag "ERR" or "IMG"; a byte that breaks the tag
//   restarts the hunt and is dropped. An error frame has one length byte,
//   an image frame LENGTH_BYTES length bytes, least significant first.
//   Each payload byte leaves on the rsp_ channel with the frame kind in
//   rsp_tuser and rsp_tlast on the final byte. A zero length yields nothing.
//   Throughput: one byte per cycle while the output buffer has space.
//   A payload byte is registered in the output buffer before it leaves on rsp_.
//   Reset: the parser returns to hunting and the output buffer is emptied.
//   Stall: the result register plus a skid register hold two transactions;
//   req_tready drops only when both are full, so one more payload byte is taken
//   after the receiver stalls.
module tagged_length_frame_parser
   import tlfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] payload_byte
   output logic       rsp_tuser,   // [0] frame_kind
   output logic       rsp_tlast
);

   logic       byte_accept;
   logic       result_valid;
   logic       space;
   result_type result;
   result_type out_data;

   assign req_tready  = space;
   assign byte_accept = req_tvalid && space;

   tlfp_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_accept  (byte_accept),
      .rx_byte      (req_tdata),
      .result_valid (result_valid),
      .result       (result)
   );

   tlfp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (byte_accept && result_valid),
      .push_data (result),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   // Unpack the result transaction onto the stream ports
   assign rsp_tdata = out_data.payload_byte;
   assign rsp_tuser = out_data.frame_kind;
   assign rsp_tlast = out_data.last_byte;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for tagged_length_frame_parser: directed frames, then random traffic.
// Depends on tlfp_pkg and the parser RTL; results are predicted here and checked in order.
module tb_top;
   import tlfp_pkg::*;

   localparam int MAX_GAP        = 18;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int TAIL_CYCLES    = 20;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;

   // Parser state as predicted by the testbench
   phase_type   parse_phase = PH_HUNT;
   logic        frame_kind  = KIND_ERR;
   int          len_bytes_seen = 0;
   logic [31:0] bytes_left  = '0;
   result_type  expected_payload[$];

   bit send_calm = 1'b0;
   bit recv_calm = 1'b0;
   int mismatch_count = 0;
   int idle_cycles = 0;
   result_type want;

   tagged_length_frame_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("%0t MISMATCH %s", $time, what);
      mismatch_count++;
   endtask

   // Return to hunting with a clear length
   task automatic restart_hunt();
      parse_phase    = PH_HUNT;
      len_bytes_seen = 0;
      bytes_left     = '0;
   endtask

   // Length complete: go to payload, or hunt again on a zero length
   task automatic close_length();
      len_bytes_seen = 0;
      if (bytes_left == 0) restart_hunt();
      else parse_phase = PH_DATA;
   endtask

   task automatic open_frame(input logic kind);
      frame_kind     = kind;
      len_bytes_seen = 0;
      bytes_left     = '0;
      parse_phase    = PH_LEN;
   endtask

   // Advance the predicted parser by one accepted byte
   task automatic model_byte(input logic [7:0] b);
      result_type r;
      case (parse_phase)
         PH_HUNT: begin
            if (b == CHAR_E) parse_phase = PH_E;
            else if (b == CHAR_I) parse_phase = PH_I;
         end
         PH_E:  parse_phase = (b == CHAR_R) ? PH_ER : PH_HUNT;
         PH_ER: begin
            if (b == CHAR_R) open_frame(KIND_ERR);
            else parse_phase = PH_HUNT;
         end
         PH_I:  parse_phase = (b == CHAR_M) ? PH_IM : PH_HUNT;
         PH_IM: begin
            if (b == CHAR_G) open_frame(KIND_IMG);
            else parse_phase = PH_HUNT;
         end
         PH_LEN: begin
            if (frame_kind == KIND_ERR) begin
               bytes_left = {24'h0, b};
               close_length();
            end else begin
               // bytes past the count width are consumed but ignored
               if (len_bytes_seen < COUNT_BYTES)
                  bytes_left = bytes_left | ({24'h0, b} << (8 * len_bytes_seen));
               len_bytes_seen++;
               if (len_bytes_seen >= LENGTH_BYTES) close_length();
            end
         end
         PH_DATA: begin
            r.payload_byte = b;
            r.frame_kind   = frame_kind;
            r.last_byte    = (bytes_left <= 1);
            expected_payload.push_back(r);
            if (r.last_byte) restart_hunt();
            else bytes_left = bytes_left - 1;
         end
         default: restart_hunt();
      endcase
   endtask

   // Send one byte after a random gap; valid stays high on return
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      model_byte(value);
   endtask

   // Drop valid and hold until every expected payload byte has left
   task automatic hold_off();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_payload.size() != 0) @(posedge clock);
   endtask

   task automatic send_tag(input logic kind);
      if (kind == KIND_ERR) begin
         send_byte(CHAR_E);
         send_byte(CHAR_R);
         send_byte(CHAR_R);
      end else begin
         send_byte(CHAR_I);
         send_byte(CHAR_M);
         send_byte(CHAR_G);
      end
   endtask

   // Error frames carry one length byte, image frames LENGTH_BYTES little-endian
   task automatic send_length(input logic kind, input logic [31:0] len);
      if (kind == KIND_ERR) begin
         send_byte(len[7:0]);
      end else begin
         for (int i = 0; i < LENGTH_BYTES; i++)
            send_byte((i < 4) ? len[8*i +: 8] : 8'h00);
      end
   endtask

   task automatic test_broken_tags();
      // second E breaks the tag and is dropped, so the R R that follow are noise
      send_byte(CHAR_E);
      send_byte(CHAR_E);
      send_byte(CHAR_R);
      send_byte(CHAR_R);
   endtask

   task automatic test_error_frame();
      send_tag(KIND_ERR);
      send_length(KIND_ERR, 32'd2);
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   task automatic test_image_frame();
      send_tag(KIND_IMG);
      send_length(KIND_IMG, 32'd1);
      send_byte(8'h5A);
   endtask

   task automatic test_zero_length();
      send_tag(KIND_IMG);
      send_length(KIND_IMG, 32'd0);
      hold_off();
   endtask

   task automatic test_random_traffic(input int target);
      int framed;
      int choice;
      int pick;
      logic kind;
      logic [31:0] len;
      logic [7:0] wrong;
      framed = 0;
      while (framed < target) begin
         // redraw calm stretches now and then
         if ($urandom_range(0, 9) == 0) begin
            send_calm = ($urandom_range(0, 3) == 0);
            recv_calm = ($urandom_range(0, 3) == 0);
         end
         choice = $urandom_range(0, 9);
         if (choice == 0) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end else if (choice == 1) begin
            // broken tag: one or two good characters, then a byte that breaks it
            kind  = 1'($urandom_range(0, 1));
            pick  = $urandom_range(1, 2);
            wrong = ($urandom_range(0, 1) == 0) ? (($urandom_range(0, 1) == 0) ? CHAR_E : CHAR_I)
                                                : 8'($urandom_range(0, 255));
            if (kind == KIND_ERR) begin
               send_byte(CHAR_E);
               if (pick == 2) send_byte(CHAR_R);
               if (wrong == CHAR_R) wrong = wrong ^ 8'h01;
            end else begin
               send_byte(CHAR_I);
               if (pick == 2) send_byte(CHAR_M);
               if (wrong == ((pick == 2) ? CHAR_G : CHAR_M)) wrong = wrong ^ 8'h01;
            end
            send_byte(wrong);
         end else begin
            kind = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 29);
            if (pick == 0) len = 0;
            else if (pick == 1)
               len = (kind == KIND_ERR) ? 32'($urandom_range(13, 255))
                                        : 32'($urandom_range(13, 511));
            else len = 32'($urandom_range(1, 12));
            send_tag(kind);
            send_length(kind, len);
            for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
            framed += 3 + ((kind == KIND_ERR) ? 1 : LENGTH_BYTES) + int'(len);
            if ($urandom_range(0, 24) == 0) hold_off();
         end
      end
      send_calm = 1'b0;
      recv_calm = 1'b0;
   endtask

   // Upper length bytes set: the frame outlasts the run, so this comes last
   task automatic test_long_image();
      send_tag(KIND_IMG);
      send_length(KIND_IMG, 32'h12345678);
      repeat (40) send_byte(8'($urandom_range(0, 255)));
   endtask

   // Receiver: stall a random number of cycles before each transaction
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         stall = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
         repeat (stall) begin
            rsp_tready <= 1'b0;
            @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Check each result transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_payload.size() == 0) begin
            report_mismatch($sformatf("unexpected result data %h", rsp_tdata));
         end else begin
            want = expected_payload.pop_front();
            if (rsp_tdata !== want.payload_byte)
               report_mismatch($sformatf("payload got %h want %h", rsp_tdata, want.payload_byte));
            if (rsp_tuser !== want.frame_kind)
               report_mismatch($sformatf("kind got %b want %b", rsp_tuser, want.frame_kind));
            if (rsp_tlast !== want.last_byte)
               report_mismatch($sformatf("last got %b want %b", rsp_tlast, want.last_byte));
         end
      end
   end

   // Watchdog: count cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_broken_tags();
      test_error_frame();
      test_image_frame();
      test_zero_length();
      test_random_traffic(950);
      test_long_image();
      hold_off();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/tlfp_pkg.sv
hdl/tlfp_parser.sv
hdl/tlfp_out_buf.sv
hdl/tagged_length_frame_parser.sv
test/tb_top.sv
